>>> rtl/wsi_pkg.sv
// ----------------------------------------------------------------------------
// wsi_pkg
// Types and constants shared by the windowed sample integrator modules.
// ----------------------------------------------------------------------------
package wsi_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REDUCE_MODE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ENABLE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH   = 8'd3;

  // reduction modes
  localparam logic [2:0] MODE_TRAP     = 3'd0;
  localparam logic [2:0] MODE_ABS_TRAP = 3'd1;
  localparam logic [2:0] MODE_SUM      = 3'd2;
  localparam logic [2:0] MODE_ABS_SUM  = 3'd3;
  localparam logic [2:0] MODE_SQUARES  = 3'd4;

  // how the term stage forms the magnitude
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_HALF   = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;
  localparam logic [1:0] KIND_SHIFT  = 2'd3;

  localparam logic signed [31:0] WIN_LOW_RESET  = 32'sh8000_0000;
  localparam logic signed [31:0] WIN_HIGH_RESET = 32'sh7FFF_FFFF;

  localparam logic [63:0] SMAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN64  = 64'h8000_0000_0000_0000;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         reduce_mode;
    logic               window_enable;
    logic signed [31:0] window_low;
    logic signed [31:0] window_high;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        take;
    logic        last;
    logic        neg;
    logic [1:0]  kind;
    logic [32:0] opa;
    logic [32:0] opb;
  } op_t;

  typedef struct packed {
    logic        valid;
    logic        take;
    logic        last;
    logic        neg;
    logic [63:0] mag;
  } term_t;

endpackage

>>> rtl/wsi_front.sv
// ----------------------------------------------------------------------------
// wsi_front
// Input register, window decision and operand selection per reduction mode.
// ----------------------------------------------------------------------------
module wsi_front
  import wsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [31:0] x_position,
  input  logic [31:0] y_value,
  input  logic        last_sample,
  output op_t         op
);

  logic               s1_valid;
  logic signed [31:0] s1_x;
  logic signed [31:0] s1_y;
  logic               s1_last;

  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic               have_point;
  logic               win_closed;

  logic               fire;
  logic               take;
  logic               close;
  logic signed [32:0] dx;
  logic signed [32:0] ys;
  logic [32:0]        dx_mag;
  logic [32:0]        ys_mag;
  logic [31:0]        y_mag;
  op_t                op_next;

  assign fire = s1_valid && adv;

  always_comb begin
    take  = !win_closed;
    close = 1'b0;
    if (take && cfg.window_enable) begin
      if (s1_x < cfg.window_low) begin
        take = 1'b0;
      end else if (s1_x > cfg.window_high) begin
        take  = 1'b0;
        close = 1'b1;
      end
    end
  end

  always_comb begin
    dx     = {s1_x[31], s1_x} - {prev_x[31], prev_x};
    ys     = {s1_y[31], s1_y} + {prev_y[31], prev_y};
    dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
    ys_mag = ys[32] ? 33'(-ys) : 33'(ys);
    y_mag  = s1_y[31] ? 32'(-s1_y) : 32'(s1_y);

    op_next       = '0;
    op_next.valid = s1_valid;
    op_next.take  = take;
    op_next.last  = s1_last;
    unique case (cfg.reduce_mode)
      MODE_TRAP, MODE_ABS_TRAP: begin
        if (have_point) begin
          op_next.kind = KIND_HALF;
          op_next.opa  = dx_mag;
          op_next.opb  = ys_mag;
          op_next.neg  = (cfg.reduce_mode == MODE_TRAP) && (dx[32] != ys[32]);
        end
      end
      MODE_SUM: begin
        op_next.kind = KIND_SHIFT;
        op_next.opa  = {1'b0, y_mag};
        op_next.neg  = s1_y[31];
      end
      MODE_ABS_SUM: begin
        op_next.kind = KIND_SHIFT;
        op_next.opa  = {1'b0, y_mag};
      end
      MODE_SQUARES: begin
        op_next.kind = KIND_SQUARE;
        op_next.opa  = {1'b0, y_mag};
        op_next.opb  = {1'b0, y_mag};
      end
      default: begin
        op_next.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_x    <= x_position;
      s1_y    <= y_value;
      s1_last <= last_sample;
    end
  end

  // per-set state; the final transfer of a set leaves it cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_y     <= '0;
      have_point <= 1'b0;
      win_closed <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        prev_x     <= '0;
        prev_y     <= '0;
        have_point <= 1'b0;
        win_closed <= 1'b0;
      end else begin
        if (take) begin
          prev_x     <= s1_x;
          prev_y     <= s1_y;
          have_point <= 1'b1;
        end
        if (close) begin
          win_closed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= '0;
    end else if (adv) begin
      op <= op_next;
    end
  end

endmodule

>>> rtl/wsi_term.sv
// ----------------------------------------------------------------------------
// wsi_term
// Forms the unsigned term magnitude: halved product, square or shifted sample.
// ----------------------------------------------------------------------------
module wsi_term
  import wsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  op_t   op,
  output term_t term
);

  logic [63:0] prod;
  term_t       term_next;

  assign prod = op.opa[31:0] * op.opb[31:0];

  always_comb begin
    term_next       = '0;
    term_next.valid = op.valid;
    term_next.take  = op.take;
    term_next.last  = op.last;
    term_next.neg   = op.neg;
    unique case (op.kind)
      KIND_HALF: begin
        // an operand of exactly 2^32 turns the product into a shift
        if (op.opa[32]) begin
          term_next.mag = {op.opb, 31'b0};
        end else if (op.opb[32]) begin
          term_next.mag = {op.opa, 31'b0};
        end else begin
          term_next.mag = {1'b0, prod[63:1]};
        end
      end
      KIND_SQUARE: term_next.mag = prod;
      KIND_SHIFT:  term_next.mag = {16'b0, op.opa[31:0], 16'b0};
      default:     term_next.mag = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term <= '0;
    end else if (adv) begin
      term <= term_next;
    end
  end

endmodule

>>> rtl/wsi_accum.sv
// ----------------------------------------------------------------------------
// wsi_accum
// Saturating Q32.32 accumulator, sample count and result register.
// ----------------------------------------------------------------------------
module wsi_accum
  import wsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  term_t       term,
  output logic        hold,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [63:0] total,
  output logic        saturated,
  output logic [15:0] points_used
);

  logic [63:0] run_total;
  logic        clip_seen;
  logic [15:0] count;

  logic        fire;
  logic [65:0] addend;
  logic [65:0] sum;
  logic [63:0] sat_val;
  logic        clipped;
  logic [63:0] total_next;
  logic        clip_next;
  logic [15:0] count_next;

  // a final transfer needs the result register free
  assign hold = term.valid && term.last && out_valid && !out_ready;
  assign fire = term.valid && adv;

  always_comb begin
    addend = term.neg ? 66'(-{2'b0, term.mag}) : {2'b0, term.mag};
    sum    = {{2{run_total[63]}}, run_total} + addend;
    if (!sum[65] && (sum[64:63] != 2'b00)) begin
      sat_val = SMAX64;
      clipped = 1'b1;
    end else if (sum[65] && (sum[64:63] != 2'b11)) begin
      sat_val = SMIN64;
      clipped = 1'b1;
    end else begin
      sat_val = sum[63:0];
      clipped = 1'b0;
    end
    total_next = term.take ? sat_val : run_total;
    clip_next  = clip_seen || (term.take && clipped);
    count_next = (term.take && (count != CNT_MAX)) ? count + 16'd1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_total <= '0;
      clip_seen <= 1'b0;
      count     <= '0;
    end else if (fire) begin
      if (term.last) begin
        run_total <= '0;
        clip_seen <= 1'b0;
        count     <= '0;
      end else begin
        run_total <= total_next;
        clip_seen <= clip_next;
        count     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && term.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && term.last) begin
      total       <= total_next;
      saturated   <= clip_next;
      points_used <= count_next;
    end
  end

endmodule

>>> rtl/windowed_sample_integrator_core.sv
// result path: the sample marked last passes the input, operand, term and result registers
// throughput: one sample per cycle when not stalled; the accumulator loop (66-bit add and clamp) sets this
// the input stalls only while a result waits and the next final sample reaches the accumulator
// reset: registers return to their defaults, all per-set state and the pipeline are cleared
// ----------------------------------------------------------------------------
// windowed_sample_integrator_core
// Windowed trapezoid, sum and sum-of-squares reduction of Q16.16 samples.
// ----------------------------------------------------------------------------
module windowed_sample_integrator_core
  import wsi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            x_position,
  input  logic [31:0]            y_value,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            total,
  output logic                   saturated,
  output logic [15:0]            points_used
);

  cfg_t  cfg;
  op_t   op;
  term_t term;
  logic  hold;
  logic  adv;

  assign adv      = !hold;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reduce_mode   <= MODE_TRAP;
      cfg.window_enable <= 1'b0;
      cfg.window_low    <= WIN_LOW_RESET;
      cfg.window_high   <= WIN_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REDUCE_MODE:   cfg.reduce_mode   <= cfg_data[2:0];
        REG_WINDOW_ENABLE: cfg.window_enable <= cfg_data[0];
        REG_WINDOW_LOW:    cfg.window_low    <= cfg_data;
        REG_WINDOW_HIGH:   cfg.window_high   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wsi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .x_position  (x_position),
    .y_value     (y_value),
    .last_sample (last_sample),
    .op          (op)
  );

  wsi_term u_term (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .op   (op),
    .term (term)
  );

  wsi_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .term        (term),
    .hold        (hold),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .total       (total),
    .saturated   (saturated),
    .points_used (points_used)
  );

`ifndef SYNTHESIS
  // the input only stalls behind a result that is not being taken
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty set reports a zero total and no clipping
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (points_used == 16'd0)) |-> ((total == 64'd0) && !saturated))
    else $error("empty set with nonzero total");

  // a stage that stalls keeps its item
  assert property (@(posedge clk) disable iff (rst)
    hold |=> (term.valid && term.last))
    else $error("final item lost during stall");
`endif

endmodule

>>> tb/windowed_sample_integrator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_integrator_core_tb
// Self-checking bench for the windowed sample integrator. A directed table
// walks the reduction modes, the window and the saturation corners. Random
// sample sets then run under random idling on both channels and a long
// output hold. Every result is checked against the value typed in the table
// where there is one, else against a cycle-free model kept in the bench.
// ----------------------------------------------------------------------------
module windowed_sample_integrator_core_tb;
  import wsi_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RESULT_LATENCY = 3;
  localparam int LONG_HOLD      = 80;
  localparam int MAX_IDLE       = 5;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_SAMPLES  = 75;

  // modes with no reduction behind them
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [63:0] total;
    logic        saturated;
    logic [15:0] points_used;
  } set_result_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [31:0]            reg_value;
    logic [31:0]            x;
    logic [31:0]            y;
    bit                     last;
    bit                     pinned;
    set_result_t            want;
  } stim_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [31:0]            x_position;
  logic [31:0]            y_value;
  logic                   last_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [63:0]            total;
  logic                   saturated;
  logic [15:0]            points_used;

  // travels with the payload: the result of this set is typed in the table
  logic item_pinned;

  bit calm;
  bit long_hold_req;
  int mismatches;

  stim_row_t   directed_rows[$];
  set_result_t expected_totals[$];
  set_result_t typed_totals[$];

  // integrator model: registers and per-set state
  logic [2:0]         cur_mode;
  bit                 cur_win_en;
  logic signed [31:0] cur_win_lo;
  logic signed [31:0] cur_win_hi;
  logic [63:0]        area_acc;
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  bit                 have_anchor;
  bit                 window_shut;
  bit                 clipped;
  logic [15:0]        sample_count;

  set_result_t predicted;
  set_result_t seen;
  set_result_t oldest;

  windowed_sample_integrator_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_position  (x_position),
    .y_value     (y_value),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .total       (total),
    .saturated   (saturated),
    .points_used (points_used)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // signed 64-bit accumulate with clamping at both ends
  function automatic void add_term(input bit neg, input logic [63:0] mag);
    logic signed [65:0] s;
    s = $signed({{2{area_acc[63]}}, area_acc});
    if (neg) s = s - $signed({2'b00, mag});
    else     s = s + $signed({2'b00, mag});
    if (s > $signed({2'b00, SMAX64})) begin
      area_acc = SMAX64;
      clipped  = 1'b1;
    end else if (s < $signed({2'b11, SMIN64})) begin
      area_acc = SMIN64;
      clipped  = 1'b1;
    end else begin
      area_acc = s[63:0];
    end
  endfunction

  function automatic bit integrate_sample(input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input bit last,
                                          output set_result_t res);
    bit                 take;
    logic signed [32:0] dx;
    logic signed [32:0] ys;
    logic [32:0]        y_mag;
    logic [65:0]        prod;
    logic [63:0]        sq;
    take = !window_shut;
    if (take && cur_win_en) begin
      if (x < cur_win_lo) begin
        take = 1'b0;
      end else if (x > cur_win_hi) begin
        window_shut = 1'b1;
        take        = 1'b0;
      end
    end
    if (take) begin
      y_mag = mag33({y[31], y});
      case (cur_mode)
        MODE_TRAP, MODE_ABS_TRAP: begin
          // first point of the set only anchors the next trapezoid
          if (have_anchor) begin
            dx   = {x[31], x} - {last_x[31], last_x};
            ys   = {y[31], y} + {last_y[31], last_y};
            prod = {33'b0, mag33(dx)} * {33'b0, mag33(ys)};
            add_term(cur_mode == MODE_TRAP && (dx[32] != ys[32]), prod[64:1]);
          end
        end
        MODE_SUM:     add_term(y[31], {15'b0, y_mag, 16'b0});
        MODE_ABS_SUM: add_term(1'b0, {15'b0, y_mag, 16'b0});
        MODE_SQUARES: begin
          sq = {31'b0, y_mag} * {31'b0, y_mag};
          add_term(1'b0, sq);
        end
        default: ;
      endcase
      last_x      = x;
      last_y      = y;
      have_anchor = 1'b1;
      if (sample_count != CNT_MAX) sample_count = sample_count + 16'd1;
    end
    if (!last) return 1'b0;
    res.total       = area_acc;
    res.saturated   = clipped;
    res.points_used = sample_count;
    area_acc     = '0;
    last_x       = '0;
    last_y       = '0;
    have_anchor  = 1'b0;
    window_shut  = 1'b0;
    clipped      = 1'b0;
    sample_count = '0;
    return 1'b1;
  endfunction

  initial begin
    cur_mode     = MODE_TRAP;
    cur_win_en   = 1'b0;
    cur_win_lo   = WIN_LOW_RESET;
    cur_win_hi   = WIN_HIGH_RESET;
    area_acc     = '0;
    last_x       = '0;
    last_y       = '0;
    have_anchor  = 1'b0;
    window_shut  = 1'b0;
    clipped      = 1'b0;
    sample_count = '0;
  end

  // predict on every input transfer, check on every output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (integrate_sample(x_position, y_value, last_sample, predicted)) begin
          if (item_pinned) expected_totals.push_back(typed_totals.pop_front());
          else             expected_totals.push_back(predicted);
        end
      end
      if (out_valid && out_ready) begin
        seen.total       = total;
        seen.saturated   = saturated;
        seen.points_used = points_used;
        if (expected_totals.size() == 0) begin
          $display("%0t: result with nothing expected, total %h saturated %b points %0d",
                   $time, total, saturated, points_used);
          mismatches++;
        end else begin
          oldest = expected_totals.pop_front();
          if (seen.total !== oldest.total) begin
            $display("%0t: total expected %h got %h", $time, oldest.total, seen.total);
            mismatches++;
          end
          if (seen.saturated !== oldest.saturated) begin
            $display("%0t: saturated expected %b got %b", $time,
                     oldest.saturated, seen.saturated);
            mismatches++;
          end
          if (seen.points_used !== oldest.points_used) begin
            $display("%0t: points_used expected %0d got %0d", $time,
                     oldest.points_used, seen.points_used);
            mismatches++;
          end
        end
      end
    end
  end

  // result side: random stalls per result, plus an occasional long hold
  initial begin : receiver
    int hold;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, expected_totals.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void put_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
    stim_row_t r;
    r.is_cfg    = 1'b1;
    r.reg_index = idx;
    r.reg_value = value;
    r.x         = '0;
    r.y         = '0;
    r.last      = 1'b0;
    r.pinned    = 1'b0;
    r.want      = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void put_sample(input logic [31:0] x, input logic [31:0] y,
                                     input bit last);
    stim_row_t r;
    r.is_cfg    = 1'b0;
    r.reg_index = '0;
    r.reg_value = '0;
    r.x         = x;
    r.y         = y;
    r.last      = last;
    r.pinned    = 1'b0;
    r.want      = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void put_checked(input logic [31:0] x, input logic [31:0] y,
                                      input logic [63:0] want_total, input bit want_sat,
                                      input logic [15:0] want_count);
    put_sample(x, y, 1'b1);
    directed_rows[directed_rows.size()-1].pinned = 1'b1;
    directed_rows[directed_rows.size()-1].want   = {want_total, want_sat, want_count};
  endfunction

  function automatic logic [31:0] pick_y();
    case ($urandom_range(0, 9))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2, 3, 4: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_sample(input logic [31:0] x, input logic [31:0] y,
                              input bit last, input bit pinned);
    int gap;
    in_valid    <= 1'b1;
    x_position  <= x;
    y_value     <= y;
    last_sample <= last;
    item_pinned <= pinned;
    do @(posedge clk); while (in_ready !== 1'b1);
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every result, then let the pipeline empty of resultless samples
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  // leaves cfg_write high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_REDUCE_MODE:   cur_mode   = value[2:0];
      REG_WINDOW_ENABLE: cur_win_en = value[0];
      REG_WINDOW_LOW:    cur_win_lo = value;
      REG_WINDOW_HIGH:   cur_win_hi = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [2:0] mode, input bit en,
                           input logic [31:0] lo, input logic [31:0] hi);
    settle();
    // junk above the field width must be dropped
    write_reg(REG_REDUCE_MODE, ($urandom & 32'hFFFF_FFF8) | {29'b0, mode});
    write_reg(REG_WINDOW_ENABLE, ($urandom & 32'hFFFF_FFFE) | {31'b0, en});
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    cfg_write <= 1'b0;
  endtask

  task automatic send_set(input int len, input bit noisy, input bit close);
    logic [31:0] x;
    logic [31:0] step;
    if (cur_win_en) x = cur_win_lo - $urandom_range(0, 32'h4_0000);
    else            x = $urandom;
    for (int i = 0; i < len; i++) begin
      if (noisy) x = $urandom;
      offer_sample(x, pick_y(), close && (i == len - 1), 1'b0);
      case ($urandom_range(0, 7))
        0:       step = '0;
        1:       step = $urandom;
        default: step = $urandom_range(0, 32'h2_0000);
      endcase
      x = x + step;
    end
  endtask

  initial begin : stimulus
    bit          cfg_burst;
    bit          squeeze;
    bit          close;
    bit          en;
    logic [2:0]  mode;
    logic [31:0] lo;
    logic [31:0] hi;
    int          sent;
    int          len;

    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    x_position  <= '0;
    y_value     <= '0;
    last_sample <= 1'b0;
    item_pinned <= 1'b0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    mismatches    = 0;
    cfg_burst     = 1'b0;

    // lone sample right after reset adds no area
    put_checked(32'h0, 32'h0005_0000, 64'h0, 1'b0, 16'd1);
    // unit square
    put_sample(32'h0, Q_ONE, 1'b0);
    put_checked(Q_ONE, Q_ONE, 64'h1_0000_0000, 1'b0, 16'd2);
    // full x span, y pair summing to minus one lsb
    put_sample(S32_MIN, S32_MAX, 1'b0);
    put_sample(S32_MAX, S32_MIN, 1'b1);
    // full x span at the most negative y
    put_sample(S32_MIN, S32_MIN, 1'b0);
    put_sample(S32_MAX, S32_MIN, 1'b1);
    // x running backwards
    put_sample(32'h0000_0005, 32'h0000_0003, 1'b0);
    put_sample(32'h0000_0002, 32'h0000_0003, 1'b1);
    put_cfg(REG_REDUCE_MODE, 32'(MODE_ABS_TRAP));
    put_sample(Q_ONE, 32'hFFFD_0000, 1'b0);
    put_sample(32'h0003_0000, 32'hFFFF_0000, 1'b1);
    put_cfg(REG_REDUCE_MODE, 32'(MODE_SUM));
    put_sample(32'h0, S32_MIN, 1'b0);
    put_sample(32'h0, S32_MAX, 1'b0);
    put_sample(32'h0, 32'h0, 1'b1);
    put_cfg(REG_REDUCE_MODE, 32'(MODE_ABS_SUM));
    put_sample(32'h0, S32_MIN, 1'b0);
    put_sample(S32_MAX, 32'hFFFF_FFFF, 1'b1);
    // full-scale squares overflow the accumulator
    put_cfg(REG_REDUCE_MODE, 32'(MODE_SQUARES));
    put_sample(32'h0, S32_MIN, 1'b0);
    put_sample(32'h0, S32_MIN, 1'b0);
    put_sample(32'h0, S32_MIN, 1'b0);
    put_checked(32'h0, S32_MIN, SMAX64, 1'b1, 16'd4);
    // unused modes count samples but add nothing
    put_cfg(REG_REDUCE_MODE, 32'(MODE_SPARE_LO));
    put_checked(Q_ONE, 32'h0007_0000, 64'h0, 1'b0, 16'd1);
    put_cfg(REG_REDUCE_MODE, 32'(MODE_SPARE_HI));
    put_sample(32'h0, S32_MAX, 1'b0);
    put_checked(Q_ONE, S32_MIN, 64'h0, 1'b0, 16'd2);
    // window 1.0 to 3.0: skip below, close above, ignore after closing
    put_cfg(REG_REDUCE_MODE, 32'(MODE_TRAP));
    put_cfg(REG_WINDOW_ENABLE, 32'd1);
    put_cfg(REG_WINDOW_LOW, Q_ONE);
    put_cfg(REG_WINDOW_HIGH, 32'h0003_0000);
    put_sample(32'h0, Q_ONE, 1'b0);
    put_sample(Q_ONE, Q_ONE, 1'b0);
    put_sample(32'h0003_0000, Q_ONE, 1'b0);
    put_sample(32'h0004_0000, Q_ONE, 1'b0);
    put_checked(32'h0002_0000, Q_ONE, 64'h2_0000_0000, 1'b0, 16'd2);
    // empty window, low above high
    put_cfg(REG_WINDOW_LOW, 32'h0003_0000);
    put_cfg(REG_WINDOW_HIGH, Q_ONE);
    put_checked(32'h0002_0000, Q_ONE, 64'h0, 1'b0, 16'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_burst) settle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
        cfg_burst = 1'b1;
      end else begin
        if (cfg_burst) begin
          cfg_write <= 1'b0;
          cfg_burst = 1'b0;
        end
        if (directed_rows[i].pinned) typed_totals.push_back(directed_rows[i].want);
        offer_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                     directed_rows[i].pinned);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      en   = (p < 2) ? 1'b1 : 1'($urandom_range(0, 1));
      if (p == 0) begin
        lo = S32_MIN;
        hi = S32_MAX;
      end else if (p == 1) begin
        lo = S32_MAX;
        hi = S32_MIN;
      end else if ($urandom_range(0, 3) == 0) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
        hi = lo + $urandom_range(0, 32'h8_0000);
      end
      squeeze = (p == 5);
      configure(mode, en, lo, hi);
      // sender floods short sets while the receiver sits on its hands
      calm = squeeze || (p % 4 == 3);
      if (squeeze) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        len = squeeze ? $urandom_range(1, 2) : $urandom_range(1, 10);
        // the final set of a phase is sometimes left open across the reconfigure
        close = (sent + len < PHASE_SAMPLES) || ($urandom_range(0, 2) != 0);
        send_set(len, $urandom_range(0, 7) == 0, close);
        sent += len;
      end
      calm = 1'b0;
    end

    settle();
    if (mismatches == 0) $display("Simulation PASSED");
    else                 $display("Simulation FAILED");
    $finish;
  end

endmodule
